>>> rtl/ec_point_add_and_scalar_mult_defines.svh
// ---------------------------------------------------------------------------
// EC point unit assertion macros
// Shared assertion helpers for the elliptic-curve point arithmetic block.
// ---------------------------------------------------------------------------
`ifndef EC_POINT_ADD_AND_SCALAR_MULT_DEFINES_SVH
`define EC_POINT_ADD_AND_SCALAR_MULT_DEFINES_SVH
`ifndef SYNTHESIS
`define ECP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ECP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ECP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ECP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ecp_pkg.sv
// ---------------------------------------------------------------------------
// EC point unit package
// Payload types and constants shared by the point arithmetic block.
// ---------------------------------------------------------------------------
package ecp_pkg;
    localparam int FW = 30;
    localparam int SW = 30;

    typedef struct packed {
        logic          opcode;
        logic [FW-1:0] first_x;
        logic [FW-1:0] first_y;
        logic [FW-1:0] second_x;
        logic [FW-1:0] second_y;
        logic [SW-1:0] scalar;
    } t_req;

    typedef struct packed {
        logic [FW-1:0] result_x;
        logic [FW-1:0] result_y;
        logic          at_infinity;
    } t_res;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef enum logic [2:0] {
        MOP_MUL = 3'd0,
        MOP_ADD = 3'd1,
        MOP_SUB = 3'd2,
        MOP_RED = 3'd3,
        MOP_INV = 3'd4
    } t_mop;

    typedef struct packed {
        logic start;
        t_mop op;
    } t_mcmd;
endpackage

>>> rtl/ecp_alu.sv
// ---------------------------------------------------------------------------
// EC modular arithmetic unit
// Modular add and subtract, bit-serial modular multiply, reduction and extended-Euclid inverse.
// ---------------------------------------------------------------------------
module ecp_alu import ecp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mcmd         i_cmd,
    input  logic [FW-1:0] i_a,
    input  logic [FW-1:0] i_b,
    input  logic [FW-1:0] i_m,
    output logic          o_done,
    output logic [FW-1:0] o_r
);
    // One step per cycle; each op is shift/add/compare on up to FW+2 bits.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_RED  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_QT   = 7'b0010000,
        S_TUP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_st;

    localparam int CW = $clog2(FW + 1);

    t_st           r_st;
    logic [FW-1:0] r_a, r_b, r_r, r_r1, r_r2, r_t1, r_t2, r_q, r_rem, r_acc;
    logic [CW-1:0] r_cnt;
    logic [FW+1:0] w_dbl, w_sum;
    logic [FW:0]   w_trial;
    logic [FW-1:0] w_dbl_m, w_sum_m, w_tnew;

    always_comb begin
        w_dbl   = {2'b0, r_acc} + {2'b0, r_acc};
        w_dbl_m = (w_dbl >= {2'b0, i_m}) ? FW'(w_dbl - {2'b0, i_m}) : FW'(w_dbl);
        w_sum   = {2'b0, w_dbl_m} + {2'b0, r_a};
        w_sum_m = (w_sum >= {2'b0, i_m}) ? FW'(w_sum - {2'b0, i_m}) : FW'(w_sum);
        w_trial = {r_rem, r_a[FW-1]};
        w_tnew  = (r_t1 >= r_acc) ? (r_t1 - r_acc) : FW'({1'b0, r_t1} + {1'b0, i_m}
                  - {1'b0, r_acc});
    end

    assign o_done = (r_st == S_DONE);
    assign o_r    = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_a   <= i_a;
                        r_b   <= i_b;
                        r_acc <= '0;
                        r_cnt <= CW'(FW);
                        r_rem <= '0;
                        unique case (i_cmd.op)
                            MOP_ADD: begin
                                r_r  <= ({1'b0, i_a} + {1'b0, i_b} >= {1'b0, i_m})
                                        ? FW'({1'b0, i_a} + {1'b0, i_b} - {1'b0, i_m})
                                        : FW'({1'b0, i_a} + {1'b0, i_b});
                                r_st <= S_DONE;
                            end
                            MOP_SUB: begin
                                r_r  <= (i_a >= i_b) ? (i_a - i_b)
                                        : FW'({1'b0, i_a} + {1'b0, i_m} - {1'b0, i_b});
                                r_st <= S_DONE;
                            end
                            MOP_MUL: r_st <= S_MUL;
                            MOP_RED: r_st <= S_RED;
                            MOP_INV: begin
                                r_r1 <= i_m; r_r2 <= i_a;
                                r_t1 <= '0;  r_t2 <= FW'(1);
                                r_st <= (i_a == '0) ? S_DONE : S_DIV;
                                r_r  <= '0;
                            end
                            default: r_st <= S_DONE;
                        endcase
                    end
                end
                S_MUL: begin
                    // left-to-right: acc = 2*acc + bit*a
                    r_acc <= r_b[FW-1] ? w_sum_m : w_dbl_m;
                    r_b   <= r_b << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_r  <= r_b[FW-1] ? w_sum_m : w_dbl_m;
                        r_st <= S_DONE;
                    end
                end
                S_RED: begin
                    // restoring division of a by m, keep remainder
                    r_rem <= ({1'b0, w_trial} >= {2'b0, i_m}) ?
                             FW'(w_trial - {1'b0, i_m}) : FW'(w_trial);
                    r_a   <= r_a << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_r  <= ({1'b0, w_trial} >= {2'b0, i_m}) ?
                                FW'(w_trial - {1'b0, i_m}) : FW'(w_trial);
                        r_st <= S_DONE;
                    end
                end
                S_DIV: begin
                    // quotient r1/r2 bit-serially; r_a holds dividend bits
                    if (r_cnt == CW'(FW)) begin
                        r_a   <= r_r1;
                        r_q   <= '0;
                        r_rem <= '0;
                        r_cnt <= r_cnt - 1'b1;
                        r_acc <= '0;
                    end
                    else begin
                        r_rem <= ({1'b0, {r_rem, r_a[FW-1]}} >= {2'b0, r_r2}) ?
                                 FW'({r_rem, r_a[FW-1]} - {1'b0, r_r2})
                                 : FW'({r_rem, r_a[FW-1]});
                        r_q   <= {r_q[FW-2:0],
                                  ({1'b0, {r_rem, r_a[FW-1]}} >= {2'b0, r_r2})};
                        r_a   <= r_a << 1;
                        if (r_cnt == '0) begin
                            r_st  <= S_QT;
                            r_cnt <= CW'(FW);
                        end
                        else r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_QT: begin
                    // acc = (q mod m) * t2 mod m, serial over q bits
                    if (r_cnt == CW'(FW)) begin
                        r_b   <= (r_q >= i_m) ? (r_q - i_m) : r_q;
                        r_a   <= r_t2;
                        r_acc <= '0;
                        r_cnt <= r_cnt - 1'b1;
                    end
                    else begin
                        r_acc <= r_b[FW-1] ? w_sum_m : w_dbl_m;
                        r_b   <= r_b << 1;
                        if (r_cnt == '0) r_st <= S_TUP;
                        else r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_TUP: begin
                    r_r1 <= r_r2; r_r2 <= r_rem;
                    r_t1 <= r_t2; r_t2 <= w_tnew;
                    r_cnt <= CW'(FW);
                    if (r_rem == '0) begin
                        r_r  <= r_t2;
                        r_st <= S_DONE;
                    end
                    else r_st <= S_DIV;
                end
                S_DONE:  r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/ec_point_add_and_scalar_mult.sv
// A point operation is a sequence of modular adds, subtracts and serial multiplies
// around at most one extended-Euclid inversion; a scalar multiply runs up to 2*SW
// point operations. One request at a time; the next request is accepted from the
// cycle in which the result is strobed. Receiver cannot stall. Reset (synchronous,
// active low) loads p=3, a=0 and returns to idle.
// ---------------------------------------------------------------------------
// EC point add and scalar multiply
// Affine GF(p) point arithmetic sequenced over a bit-serial modular unit.
// ---------------------------------------------------------------------------
`include "ec_point_add_and_scalar_mult_defines.svh"
module ec_point_add_and_scalar_mult import ecp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_req          i_req,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [FW-1:0] i_cfg_data,
    output logic          o_valid,
    output t_res          o_res
);
    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_PREP = 5'b00010,
        P_LOOP = 5'b00100,
        P_RUN  = 5'b01000,
        P_OUT  = 5'b10000
    } t_pst;

    localparam int KW = $clog2(SW + 1);

    t_pst          r_pst;
    logic [FW-1:0] r_p, r_a, r_ca;
    logic [FW-1:0] r_x1, r_y1, r_x2, r_y2, r_rx, r_ry, r_lam, r_t0, r_t1;
    logic          r_rinf, r_op, r_dbl_ph;
    logic [SW-1:0] r_k;
    logic [KW-1:0] r_kc;
    logic [4:0]    r_pc;
    t_mcmd         w_cmd;
    logic [FW-1:0] w_a, w_b, w_m, w_r;
    logic          w_done, r_go;
    t_mop          r_mop;
    logic [FW-1:0] r_ma, r_mb;

    assign w_m = (r_p < FW'(3)) ? FW'(3) : r_p;
    assign w_cmd.start = r_go;
    assign w_cmd.op    = r_mop;
    assign w_a = r_ma;
    assign w_b = r_mb;

    ecp_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_a(w_a), .i_b(w_b),
        .i_m(w_m), .o_done(w_done), .o_r(w_r)
    );

    assign busy = (r_pst != P_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= FW'(3);
            r_ca <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 1'b0) r_p <= i_cfg_data;
            else r_ca <= i_cfg_data;
        end
    end

    // Micro-program: pc steps; each step issues one ALU op and waits.
    // 0-4 reduce inputs and a. Point op (res op P): 10.. slope, 19.. finish.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pst   <= P_IDLE;
            r_go    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            o_valid <= 1'b0;
            unique case (r_pst)
                P_IDLE: if (start) begin
                    r_op <= i_req.opcode;
                    r_x1 <= i_req.first_x; r_y1 <= i_req.first_y;
                    r_x2 <= i_req.second_x; r_y2 <= i_req.second_y;
                    r_k  <= i_req.scalar;
                    r_pc <= 5'd0;
                    r_mop <= MOP_RED; r_ma <= i_req.first_x; r_go <= 1'b1;
                    r_pst <= P_PREP;
                end
                P_PREP: if (w_done) begin
                    r_pc <= r_pc + 5'd1;
                    r_go <= 1'b1; r_mop <= MOP_RED;
                    unique case (r_pc)
                        5'd0: begin r_x1 <= w_r; r_ma <= r_y1; end
                        5'd1: begin r_y1 <= w_r; r_ma <= r_x2; end
                        5'd2: begin r_x2 <= w_r; r_ma <= r_y2; end
                        5'd3: begin r_y2 <= w_r; r_ma <= r_ca; end
                        default: begin
                            r_a <= w_r; r_go <= 1'b0;
                            if (r_op == OP_ADD) begin
                                r_rx <= r_x1; r_ry <= r_y1; r_rinf <= 1'b0;
                                r_dbl_ph <= 1'b0;
                                r_pst <= P_LOOP;
                            end else begin
                                r_x2 <= r_x1; r_y2 <= r_y1;
                                r_rinf <= 1'b1; r_rx <= '0; r_ry <= '0;
                                r_kc <= KW'(SW); r_dbl_ph <= 1'b1;
                                r_pst <= P_LOOP;
                            end
                        end
                    endcase
                end
                P_LOOP: begin
                    // decide next point op: double (dbl_ph) or add P2
                    if (r_op == OP_MUL && r_dbl_ph && r_kc == '0) begin
                        r_pst <= P_OUT;
                    end else if (r_op == OP_MUL && !r_dbl_ph && !r_k[SW-1]) begin
                        r_k <= r_k << 1; r_dbl_ph <= 1'b1;
                    end else begin
                        // operands: R (rx,ry,rinf) with Q
                        logic dbl;
                        dbl = r_dbl_ph || (!r_rinf && r_rx == r_x2 && r_ry == r_y2);
                        if (r_dbl_ph) r_kc <= r_kc - 1'b1;
                        else r_k <= r_k << 1;
                        r_dbl_ph <= ~r_dbl_ph;
                        if (!r_dbl_ph && r_rinf) begin
                            r_rx <= r_x2; r_ry <= r_y2; r_rinf <= 1'b0;
                            if (r_op == OP_ADD) r_pst <= P_OUT;
                        end else if (r_rinf || (dbl && r_ry == '0)) begin
                            r_rinf <= 1'b1; r_rx <= '0; r_ry <= '0;
                            if (r_op == OP_ADD) r_pst <= P_OUT;
                        end else if (!dbl && r_rx == r_x2) begin
                            r_rinf <= 1'b1; r_rx <= '0; r_ry <= '0;
                            if (r_op == OP_ADD) r_pst <= P_OUT;
                        end else begin
                            if (!dbl) begin
                                r_x1 <= r_x2;
                            end else begin
                                r_x1 <= r_rx;
                            end
                            r_go <= 1'b1;
                            if (dbl) begin
                                r_pc <= 5'd10; r_mop <= MOP_MUL;
                                r_ma <= r_rx; r_mb <= r_rx;
                            end else begin
                                r_pc <= 5'd16; r_mop <= MOP_SUB;
                                r_ma <= r_ry; r_mb <= r_y2;
                            end
                            r_pst <= P_RUN;
                        end
                    end
                end
                P_RUN: if (w_done) begin
                    r_go <= 1'b1;
                    r_pc <= r_pc + 5'd1;
                    unique case (r_pc)
                        // doubling slope: (3x^2+a)/(2y)
                        5'd10: begin r_t0 <= w_r; r_mop <= MOP_ADD;
                                     r_ma <= w_r; r_mb <= w_r; end
                        5'd11: begin r_mop <= MOP_ADD; r_ma <= w_r; r_mb <= r_t0; end
                        5'd12: begin r_mop <= MOP_ADD; r_ma <= w_r; r_mb <= r_a; end
                        5'd13: begin r_t0 <= w_r; r_mop <= MOP_ADD;
                                     r_ma <= r_ry; r_mb <= r_ry; end
                        5'd14: begin r_mop <= MOP_INV; r_ma <= w_r; r_pc <= 5'd18; end
                        // addition slope: (y1-y2)/(x1-x2)
                        5'd16: begin r_t0 <= w_r; r_mop <= MOP_SUB;
                                     r_ma <= r_rx; r_mb <= r_x2; end
                        5'd17: begin r_mop <= MOP_INV; r_ma <= w_r; end
                        5'd18: begin r_mop <= MOP_MUL; r_ma <= r_t0; r_mb <= w_r; end
                        // finish: x3 = lam^2 - x1 - x2 ; y3 = lam(x1-x3) - y1
                        5'd19: begin r_lam <= w_r; r_mop <= MOP_MUL;
                                     r_ma <= w_r; r_mb <= w_r; end
                        5'd20: begin r_mop <= MOP_SUB; r_ma <= w_r; r_mb <= r_rx; end
                        5'd21: begin r_mop <= MOP_SUB; r_ma <= w_r; r_mb <= r_x1; end
                        5'd22: begin r_t1 <= w_r; r_mop <= MOP_SUB;
                                     r_ma <= r_rx; r_mb <= w_r; end
                        5'd23: begin r_mop <= MOP_MUL; r_ma <= r_lam; r_mb <= w_r; end
                        5'd24: begin r_mop <= MOP_SUB; r_ma <= w_r; r_mb <= r_ry; end
                        default: begin
                            r_go <= 1'b0;
                            r_rx <= r_t1; r_ry <= w_r; r_rinf <= 1'b0;
                            r_pst <= (r_op == OP_ADD) ? P_OUT : P_LOOP;
                        end
                    endcase
                end
                P_OUT: begin
                    o_valid <= 1'b1;
                    o_res.result_x <= r_rinf ? '0 : r_rx;
                    o_res.result_y <= r_rinf ? '0 : r_ry;
                    o_res.at_infinity <= r_rinf;
                    r_pst <= P_IDLE;
                end
                default: r_pst <= P_IDLE;
            endcase
        end
    end

    `ECP_ASSERT_IMP(a_out_idle, i_clk, i_rst_n, o_valid, r_pst == P_IDLE)
    `ECP_ASSERT_IMP(a_inf_zero, i_clk, i_rst_n, o_valid && o_res.at_infinity,
        o_res.result_x == '0 && o_res.result_y == '0)
    `ECP_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule

>>> tb/sv/ec_point_add_and_scalar_mult_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// EC point add and scalar multiply testbench
// Drives point additions and scalar multiplications under several curve and
// modulus settings, predicts each point in an affine GF(p) model and checks
// every strobed result against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module ec_point_add_and_scalar_mult_tb;
    import ecp_pkg::*;

    localparam logic CFG_PRIME = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;
    localparam longint CYCLE_LIMIT = 100_000_000;
    localparam logic [FW-1:0] FMAX = {FW{1'b1}};

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
        bit          inf;
    } t_curve_pt;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_req          i_req = '0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_idx = CFG_PRIME;
    logic [FW-1:0] i_cfg_data = '0;
    logic          o_valid;
    t_res          o_res;

    ec_point_add_and_scalar_mult uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_res(o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req        pending_reqs[$];
    t_res        expected_points[$];
    logic [FW-1:0] model_prime = 3;
    logic [FW-1:0] model_a = 0;
    int          send_idle_pct = 0;
    int          mismatches = 0;
    int          n_checked = 0;
    int          n_add = 0;
    int          n_mul = 0;
    int          n_cfg = 0;
    longint      cycles = 0;

    function automatic logic [63:0] fp_add(logic [63:0] u, logic [63:0] v, logic [63:0] m);
        logic [63:0] s;
        s = u + v;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic logic [63:0] fp_sub(logic [63:0] u, logic [63:0] v, logic [63:0] m);
        return (u >= v) ? u - v : u + (m - v);
    endfunction

    function automatic logic [63:0] fp_mul(logic [63:0] u, logic [63:0] v, logic [63:0] m);
        logic [63:0] r;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = fp_add(r, r, m);
            if (v[i]) r = fp_add(r, u, m);
        end
        return r;
    endfunction

    // Extended Euclid with the Bezout coefficient kept reduced mod m.
    function automatic logic [63:0] fp_inv(logic [63:0] d, logic [63:0] m);
        logic [63:0] r1, r2, t1, t2, q, r, t;
        r1 = m; r2 = d; t1 = 0; t2 = 1;
        while (r2 > 0) begin
            q = r1 / r2;
            r = r1 - q * r2;
            t = fp_sub(t1, fp_mul(q % m, t2, m), m);
            r1 = r2; r2 = r; t1 = t2; t2 = t;
        end
        return t1;
    endfunction

    function automatic t_curve_pt chord_finish(logic [63:0] lam, logic [63:0] x1,
                                               logic [63:0] y1, logic [63:0] x2,
                                               logic [63:0] m);
        t_curve_pt r;
        r.x = fp_sub(fp_sub(fp_mul(lam, lam, m), x1, m), x2, m);
        r.y = fp_sub(fp_mul(lam, fp_sub(x1, r.x, m), m), y1, m);
        r.inf = 0;
        return r;
    endfunction

    function automatic t_curve_pt pt_dbl(t_curve_pt e, logic [63:0] m, logic [63:0] a);
        t_curve_pt r;
        logic [63:0] num, den;
        r.x = 0; r.y = 0; r.inf = 1;
        if (e.inf || e.y == 0) return r;
        num = fp_add(fp_mul(3, fp_mul(e.x, e.x, m), m), a, m);
        den = fp_add(e.y, e.y, m);
        return chord_finish(fp_mul(num, fp_inv(den, m), m), e.x, e.y, e.x, m);
    endfunction

    function automatic t_curve_pt pt_sum(t_curve_pt e1, t_curve_pt e2, logic [63:0] m,
                                         logic [63:0] a);
        t_curve_pt r;
        logic [63:0] num, den;
        r.x = 0; r.y = 0; r.inf = 1;
        if (e1.inf) return e2;
        if (e2.inf) return e1;
        if (e1.x == e2.x) begin
            if (e1.y == e2.y) return pt_dbl(e1, m, a);
            return r;
        end
        num = fp_sub(e1.y, e2.y, m);
        den = fp_sub(e1.x, e2.x, m);
        return chord_finish(fp_mul(num, fp_inv(den, m), m), e1.x, e1.y, e2.x, m);
    endfunction

    function automatic t_res predict_point(t_req rq);
        logic [63:0] m, a;
        t_curve_pt p1, p2, acc;
        t_res o;
        m = model_prime;
        if (m < 3) m = 3;
        a = model_a % m;
        p1.x = rq.first_x % m; p1.y = rq.first_y % m; p1.inf = 0;
        if (rq.opcode == OP_ADD) begin
            p2.x = rq.second_x % m; p2.y = rq.second_y % m; p2.inf = 0;
            acc = pt_sum(p1, p2, m, a);
        end else begin
            acc.x = 0; acc.y = 0; acc.inf = 1;
            for (int i = SW - 1; i >= 0; i--) begin
                acc = pt_dbl(acc, m, a);
                if (rq.scalar[i]) acc = pt_sum(acc, p1, m, a);
            end
        end
        o.result_x = acc.inf ? '0 : acc.x[FW-1:0];
        o.result_y = acc.inf ? '0 : acc.y[FW-1:0];
        o.at_infinity = acc.inf;
        return o;
    endfunction

    function automatic t_req mk_req(logic op, logic [FW-1:0] x1, logic [FW-1:0] y1,
                                    logic [FW-1:0] x2, logic [FW-1:0] y2,
                                    logic [SW-1:0] k);
        t_req r;
        r.opcode = op; r.first_x = x1; r.first_y = y1;
        r.second_x = x2; r.second_y = y2; r.scalar = k;
        return r;
    endfunction

    // Coordinate below the effective modulus, or now and then any 30-bit value.
    function automatic logic [FW-1:0] rand_coord();
        logic [31:0] m;
        m = (model_prime < 3) ? 3 : model_prime;
        if ($urandom_range(0, 9) == 0) return FW'($urandom);
        return FW'($urandom_range(0, m - 1));
    endfunction

    function automatic t_req rand_req();
        t_req r;
        logic [31:0] m;
        m = (model_prime < 3) ? 3 : model_prime;
        r = mk_req($urandom_range(0, 3) == 0 ? OP_MUL : OP_ADD, rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), SW'($urandom));
        if (r.opcode == OP_ADD) begin
            case ($urandom_range(0, 5))
                0: begin
                    r.second_x = r.first_x; r.second_y = r.first_y;
                end
                1: begin
                    r.second_x = r.first_x;
                    r.second_y = FW'((m - (r.first_y % m)) % m);
                end
                2: r.first_y = 0;
                default: ;
            endcase
        end else if ($urandom_range(0, 7) != 0) begin
            // Short scalars keep the multiply latency down.
            r.scalar = SW'($urandom_range(0, 63));
        end
        return r;
    endfunction

    // Driver: request held until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_points.push_back(predict_point(i_req));
                if (i_req.opcode == OP_ADD) n_add++; else n_mul++;
            end
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_req <= pending_reqs.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result x=%0d y=%0d inf=%0b",
                             o_res.result_x, o_res.result_y, o_res.at_infinity);
            end else begin
                t_res e;
                e = expected_points.pop_front();
                n_checked++;
                if (o_res !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp x=%0d y=%0d inf=%0b got x=%0d y=%0d inf=%0b",
                                 n_checked, e.result_x, e.result_y, e.at_infinity,
                                 o_res.result_x, o_res.result_y, o_res.at_infinity);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_reqs.size() > 0 || start || expected_points.size() > 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [FW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PRIME) model_prime = val; else model_a = val;
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic set_curve(logic [FW-1:0] p, logic [FW-1:0] a);
        wait_idle();
        write_reg(CFG_PRIME, p);
        write_reg(CFG_CURVE_A, a);
    endtask

    task automatic random_batch(int count);
        for (int i = 0; i < count; i++) pending_reqs.push_back(rand_req());
    endtask

    int primes[10] = '{5, 7, 11, 13, 101, 251, 1009, 7919, 65521, 1073741789};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset curve: p = 3, a = 0.
        pending_reqs.push_back(mk_req(OP_ADD, 0, 1, 1, 1, 0));
        pending_reqs.push_back(mk_req(OP_MUL, 0, 1, 0, 0, 5));

        set_curve(97, 2);
        pending_reqs.push_back(mk_req(OP_ADD, 3, 6, 80, 10, 0));
        pending_reqs.push_back(mk_req(OP_ADD, 3, 6, 3, 6, 0));
        pending_reqs.push_back(mk_req(OP_ADD, 3, 6, 3, 91, 0));
        pending_reqs.push_back(mk_req(OP_ADD, 5, 0, 5, 0, 0));
        pending_reqs.push_back(mk_req(OP_ADD, 100, 103, 3, 6, 0));
        pending_reqs.push_back(mk_req(OP_MUL, 3, 6, FMAX, FMAX, 0));
        pending_reqs.push_back(mk_req(OP_MUL, 3, 6, 0, 0, 1));
        pending_reqs.push_back(mk_req(OP_MUL, 3, 6, 0, 0, 2));
        pending_reqs.push_back(mk_req(OP_MUL, 3, 6, 0, 0, 5));
        pending_reqs.push_back(mk_req(OP_MUL, 3, 6, 0, 0, {SW{1'b1}}));

        // Modulus below three acts as three; a above p is reduced.
        set_curve(1, 5);
        pending_reqs.push_back(mk_req(OP_ADD, 1, 2, 2, 1, 7));
        pending_reqs.push_back(mk_req(OP_MUL, 1, 1, 0, 0, 3));

        // All-ones modulus is composite.
        set_curve(FMAX, FMAX);
        pending_reqs.push_back(mk_req(OP_ADD, FMAX, FMAX, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_ADD, FMAX - 1, 12345, 7, FMAX - 1, 0));
        pending_reqs.push_back(mk_req(OP_MUL, FMAX - 1, 99, 0, 0, 3));

        set_curve(1073741789, 1073741788);
        pending_reqs.push_back(mk_req(OP_ADD, 1073741788, 1, 2, 3, 0));
        pending_reqs.push_back(mk_req(OP_MUL, 123456789, 987654321, 0, 0, 6));

        set_curve(15, 0);
        pending_reqs.push_back(mk_req(OP_ADD, 2, 3, 7, 11, 0));
        pending_reqs.push_back(mk_req(OP_ADD, 4, 5, 4, 5, 0));

        for (int ph = 0; ph < 6; ph++) begin
            int p;
            p = primes[$urandom_range(0, 9)];
            set_curve(FW'(p), (ph == 5) ? FW'(0) : FW'($urandom_range(0, p - 1)));
            send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 86 : 0;
            random_batch(17);
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("Checked %0d results: %0d additions, %0d scalar multiplies, %0d register writes.",
                 n_checked, n_add, n_mul, n_cfg);
        $display("Outstanding predictions at end: %0d, mismatches: %0d.",
                 expected_points.size(), mismatches);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
